>>> hdl/wasp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wrap-around slot placer package
// Field widths and the segment type shared by the placer datapath.
// ----------------------------------------------------------------------------
package wasp_pkg;

  localparam int TimeW   = 16;
  localparam int SlotW   = 12;
  localparam int BudgetW = 16;
  localparam int TaskW   = 6;
  localparam int ProcW   = 4;

  typedef struct packed {
    logic [ProcW-1:0] processor;
    logic [TimeW-1:0] start_time;
    logic [SlotW-1:0] length;
    logic [TaskW-1:0] task_out;
    logic             last_segment;
    logic             overflow_error;
  } seg_t;

endpackage

>>> hdl/wrap_around_slot_placer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wrap-around slot placer
// Places each task's share of a window onto processors in wrap-around order.
// ----------------------------------------------------------------------------
// An accepted item waits in the input register; when it is placed, its first
// segment is registered. Throughput: one item per cycle when it yields at most
// one segment and the result port does not stall; an item that yields two
// holds back the next until its second segment enters the single result port.
// Reset: window base 0, width 1, budget 0, fill processor 0 and offset 0, all stages empty.
module wrap_around_slot_placer_unit
  import wasp_pkg::*;
#(
  parameter int PROCS = 16,
  parameter int TASKS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               first_in_row,
  input  logic [TimeW-1:0]   row_start,
  input  logic [SlotW-1:0]   window_len,
  input  logic [BudgetW-1:0] idle_budget,
  input  logic [TaskW-1:0]   task_id,
  input  logic [SlotW-1:0]   amount,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ProcW-1:0]   processor,
  output logic [TimeW-1:0]   start_time,
  output logic [SlotW-1:0]   length,
  output logic [TaskW-1:0]   task_out,
  output logic               last_segment,
  output logic               overflow_error
);

  localparam int PW = $clog2(PROCS + 2);
  localparam logic [PW-1:0] PMax = PW'(PROCS);
  localparam logic [TaskW:0] TaskLimit = (TaskW + 1)'(TASKS);

  // Window state.
  logic [TimeW-1:0]   window_base;
  logic [SlotW-1:0]   window_width;
  logic [BudgetW-1:0] budget_left;
  logic [PW-1:0]      fill_processor;
  logic [SlotW-1:0]   fill_offset;

  // Input register.
  logic               hold_valid;
  logic               hold_first;
  logic [TimeW-1:0]   hold_row_start;
  logic [SlotW-1:0]   hold_window_len;
  logic [BudgetW-1:0] hold_idle_budget;
  logic [TaskW-1:0]   hold_task_id;
  logic [SlotW-1:0]   hold_amount;

  // Result register and the waiting second segment.
  seg_t out_seg;
  logic pend_valid;
  seg_t pend_seg;

  logic go;

  // Placement datapath.
  logic [TimeW-1:0]   wb;
  logic [SlotW-1:0]   ww;
  logic [BudgetW-1:0] bl;
  logic [PW-1:0]      fp, fp_a, fp_b, fp_c, fp_d;
  logic [SlotW-1:0]   fo, fo_a, fo_b, fo_c, fo_d;
  logic [SlotW:0]     fo_d_sum;
  logic [BudgetW-1:0] bl_b;
  logic [SlotW-1:0]   amt, gap, room, len1, rest;
  logic               place;
  seg_t               seg1, seg2;
  logic [BudgetW-1:0] budget_left_next;
  logic [PW-1:0]      fill_processor_next;
  logic [SlotW-1:0]   fill_offset_next;

  function automatic seg_t make_seg(input logic [PW-1:0] p, input logic [SlotW-1:0] o,
                                    input logic [TimeW-1:0] base,
                                    input logic [SlotW-1:0] len,
                                    input logic [TaskW-1:0] tid, input logic last);
    seg_t s;
    logic over;
    over = (p >= PMax);
    s.processor      = over ? '0 : ProcW'(p);
    s.start_time     = base + TimeW'(o);
    s.length         = len;
    s.task_out       = tid;
    s.last_segment   = last;
    s.overflow_error = over;
    return s;
  endfunction

  always_comb begin
    wb = hold_first ? hold_row_start : window_base;
    ww = hold_first ? ((hold_window_len == '0) ? SlotW'(1) : hold_window_len) : window_width;
    bl = hold_first ? hold_idle_budget : budget_left;
    fp = hold_first ? '0 : fill_processor;
    fo = hold_first ? '0 : fill_offset;

    amt   = (hold_amount > ww) ? ww : hold_amount;
    place = (amt != '0) && ({1'b0, hold_task_id} < TaskLimit);

    fp_a = fp;
    fo_a = fo;
    if (fp_a >= PMax) begin
      fp_a = PMax;
      fo_a = '0;
    end

    // When the item does not fit in the rest of the row, skip to the next processor if the budget covers the gap.
    gap  = ww - fo_a;
    bl_b = bl;
    fp_b = fp_a;
    fo_b = fo_a;
    if (({1'b0, fo_a} + {1'b0, amt}) > {1'b0, ww}) begin
      if ({{(BudgetW - SlotW){1'b0}}, gap} <= bl) begin
        bl_b = bl - {{(BudgetW - SlotW){1'b0}}, gap};
        fp_b = fp_a + PW'(1);
        fo_b = '0;
        if (fp_b >= PMax) begin
          fp_b = PMax;
        end
      end
    end

    room = ww - fo_b;
    len1 = (amt < room) ? amt : room;
    rest = amt - len1;

    fp_c = fp_b;
    fo_c = fo_b + len1;
    if (fo_c >= ww) begin
      fp_c = fp_b + PW'(1);
      fo_c = '0;
      if (fp_c >= PMax) begin
        fp_c = PMax;
      end
    end

    fo_d_sum = {1'b0, fo_c} + {1'b0, rest};
    fp_d     = fp_c;
    fo_d     = fo_d_sum[SlotW-1:0];
    if (fo_d_sum >= {1'b0, ww}) begin
      fp_d = fp_c + PW'(1);
      fo_d = '0;
    end
    if (fp_d >= PMax) begin
      fp_d = PMax;
      fo_d = '0;
    end

    seg1 = make_seg(fp_b, fo_b, wb, len1, hold_task_id, rest == '0);
    seg2 = make_seg(fp_c, fo_c, wb, rest, hold_task_id, 1'b1);

    if (place) begin
      budget_left_next    = bl_b;
      fill_processor_next = (rest != '0) ? fp_d : fp_c;
      fill_offset_next    = (rest != '0) ? fo_d : fo_c;
    end else begin
      budget_left_next    = bl;
      fill_processor_next = fp;
      fill_offset_next    = fo;
    end
  end

  assign go       = hold_valid && !pend_valid && (!out_valid || out_ready);
  assign in_ready = !hold_valid || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid     <= 1'b0;
      out_valid      <= 1'b0;
      pend_valid     <= 1'b0;
      window_base    <= '0;
      window_width   <= SlotW'(1);
      budget_left    <= '0;
      fill_processor <= '0;
      fill_offset    <= '0;
    end else begin
      if (in_valid && in_ready) begin
        hold_valid       <= 1'b1;
        hold_first       <= first_in_row;
        hold_row_start   <= row_start;
        hold_window_len  <= window_len;
        hold_idle_budget <= idle_budget;
        hold_task_id     <= task_id;
        hold_amount      <= amount;
      end else if (go) begin
        hold_valid <= 1'b0;
      end

      if (go) begin
        window_base    <= wb;
        window_width   <= ww;
        budget_left    <= budget_left_next;
        fill_processor <= fill_processor_next;
        fill_offset    <= fill_offset_next;
        if (place) begin
          out_seg    <= seg1;
          out_valid  <= 1'b1;
          pend_seg   <= seg2;
          pend_valid <= (rest != '0);
        end else if (out_valid && out_ready) begin
          out_valid <= 1'b0;
        end
      end else if (out_valid && out_ready) begin
        if (pend_valid) begin
          out_seg    <= pend_seg;
          pend_valid <= 1'b0;
        end else begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  assign processor      = out_seg.processor;
  assign start_time     = out_seg.start_time;
  assign length         = out_seg.length;
  assign task_out       = out_seg.task_out;
  assign last_segment   = out_seg.last_segment;
  assign overflow_error = out_seg.overflow_error;

  // A waiting second segment always sits behind a valid first one.
  assert property (@(posedge clk) disable iff (rst) pend_valid |-> out_valid)
    else $error("second segment pending without a valid result");

  // The fill position never goes beyond the pinned processor.
  assert property (@(posedge clk) disable iff (rst) fill_processor <= PMax)
    else $error("fill processor out of range");

  // A zero window width is never stored.
  assert property (@(posedge clk) disable iff (rst) window_width != '0)
    else $error("window width is zero");

  // An overflowing segment reports processor zero.
  assert property (@(posedge clk) disable iff (rst)
                   out_valid && overflow_error |-> processor == '0)
    else $error("overflow segment with nonzero processor");

  // A pending first segment of a split item is never marked as the last one.
  assert property (@(posedge clk) disable iff (rst)
                   pend_valid |-> !out_seg.last_segment && pend_seg.last_segment)
    else $error("last segment marking of a split item is wrong");

endmodule
